### sv/dtnf_pkg.sv
// Shared types and constants for the decimal text to nano fixed-point converter.
// No dependencies.
package dtnf_pkg;

  localparam int unsigned FRACTION_DIGITS = 9;

  localparam int unsigned MAG_W       = 63;
  localparam int unsigned INT_W       = 32;
  localparam int unsigned FRAC_W      = 30;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned STEP_W      = 4;
  localparam int unsigned RECIP_W     = 31;
  localparam int unsigned PROD_W      = FRAC_W + RECIP_W;
  localparam int unsigned RECIP_SHIFT = 40;
  localparam int unsigned QUOT_W      = PROD_W - RECIP_SHIFT;

  // floor(x / 1000) = (x * ceil(2^40 / 1000)) >> 40 for any 30-bit x
  localparam logic [RECIP_W-1:0] RECIP_1K = 31'd1099511628;

  localparam logic [CNT_W-1:0] PAD_DIGITS = 4'd9;

  localparam logic [2:0] ORD_MEGA  = 3'd0;
  localparam logic [2:0] ORD_KILO  = 3'd1;
  localparam logic [2:0] ORD_ONE   = 3'd2;
  localparam logic [2:0] ORD_MILLI = 3'd3;
  localparam logic [2:0] ORD_MICRO = 3'd4;
  localparam logic [2:0] ORD_NANO  = 3'd5;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [3:0] {
    PH_START = 4'b0001,
    PH_INT   = 4'b0010,
    PH_FRAC  = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_e;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PAD  = 6'b000010,
    ST_MAG  = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  typedef enum logic [1:0] {
    UOP_MAC10 = 2'b01,
    UOP_DIV   = 2'b10
  } unit_op_e;

  typedef struct packed {
    phase_e     phase_nxt;
    logic       neg_set;
    logic       int_en;
    logic       frac_en;
    logic [3:0] digit;
  } parse_upd_t;

  // last divide-by-1000 step on the fraction
  function automatic logic [STEP_W-1:0] div_last(input logic [2:0] order);
    logic [STEP_W-1:0] n;
    unique case (order)
      ORD_MILLI: n = 4'd0;
      ORD_MICRO: n = 4'd1;
      default:   n = 4'd2;
    endcase
    return n;
  endfunction

  // last multiply-by-ten step that builds the magnitude
  function automatic logic [STEP_W-1:0] mag_last(input logic [2:0] order);
    logic [STEP_W-1:0] n;
    unique case (order)
      ORD_MILLI: n = 4'd5;
      ORD_MICRO: n = 4'd2;
      default:   n = 4'd8;
    endcase
    return n;
  endfunction

  function automatic logic [STEP_W-1:0] mul_last(input logic [2:0] order);
    logic [STEP_W-1:0] n;
    unique case (order)
      ORD_MEGA: n = 4'd5;
      default:  n = 4'd2;
    endcase
    return n;
  endfunction

endpackage

### sv/decimal_text_to_nano_fixed.sv
// One text beat is taken per cycle while idle. On end of text a finishing sequence runs:
// pad the fraction to nine digits, divide it by 1000 (milli/micro/nano), build the magnitude
// by multiply-by-ten steps (not nano), scale up (mega/kilo), then load the output register.
// Input ready drops during that sequence; no new text beat is taken until it ends.
// Reset (async, active low) clears the parse state and output valid; scale order resets to one.
// Depends on dtnf_pkg, dtnf_parse, dtnf_unit.
module decimal_text_to_nano_fixed (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] value_word_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_scale_order_i
);
  import dtnf_pkg::*;

  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  logic              neg_q, neg_d;
  logic [INT_W-1:0]  int_q, int_d;
  logic [FRAC_W-1:0] frac_q, frac_d;
  logic [CNT_W-1:0]  fcnt_q, fcnt_d;
  logic [MAG_W-1:0]  acc_q, acc_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [2:0]        order_q;
  logic              out_valid_q, out_valid_d;
  logic [63:0]       value_q, value_d;

  parse_upd_t        upd;
  unit_op_e          u_op;
  logic [MAG_W-1:0]  u_a, u_b, u_y;
  logic              in_beat;

  assign in_ready_o   = (state_q == ST_IDLE);
  assign in_beat      = in_valid_i && in_ready_o;
  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign value_word_o = value_q;

  dtnf_parse u_parse (
    .phase_i (phase_q),
    .char_i  (char_code_i),
    .fcnt_i  (fcnt_q),
    .upd_o   (upd)
  );

  dtnf_unit u_unit (
    .op_i (u_op),
    .a_i  (u_a),
    .b_i  (u_b),
    .y_o  (u_y)
  );

  always_comb begin
    u_op = UOP_MAC10;
    u_a  = acc_q;
    u_b  = '0;
    unique case (state_q)
      ST_IDLE: begin
        u_a = upd.frac_en ? {{(MAG_W-FRAC_W){1'b0}}, frac_q} : {{(MAG_W-INT_W){1'b0}}, int_q};
        u_b = {{(MAG_W-4){1'b0}}, upd.digit};
      end
      ST_PAD:  u_a = {{(MAG_W-FRAC_W){1'b0}}, frac_q};
      ST_DIV: begin
        u_op = UOP_DIV;
        u_a  = {{(MAG_W-FRAC_W){1'b0}}, frac_q};
      end
      ST_MAG:  u_b = (step_q == mag_last(order_q)) ? {{(MAG_W-FRAC_W){1'b0}}, frac_q} : '0;
      default: ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    neg_d       = neg_q;
    int_d       = int_q;
    frac_d      = frac_q;
    fcnt_d      = fcnt_q;
    acc_d       = acc_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    value_d     = value_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          phase_d = upd.phase_nxt;
          if (upd.neg_set) neg_d = 1'b1;
          if (upd.int_en) int_d = u_y[INT_W-1:0];
          if (upd.frac_en) begin
            frac_d = u_y[FRAC_W-1:0];
            fcnt_d = fcnt_q + 1'b1;
          end
          if (end_of_text_i) state_d = ST_PAD;
        end
      end
      ST_PAD: begin
        if (fcnt_q == PAD_DIGITS) begin
          acc_d  = {{(MAG_W-INT_W){1'b0}}, int_q};
          step_d = '0;
          unique case (order_q) inside
            ORD_MILLI, ORD_MICRO, ORD_NANO: state_d = ST_DIV;
            default:                        state_d = ST_MAG;
          endcase
        end else begin
          frac_d = u_y[FRAC_W-1:0];
          fcnt_d = fcnt_q + 1'b1;
        end
      end
      ST_DIV: begin
        frac_d = u_y[FRAC_W-1:0];
        step_d = step_q + 1'b1;
        if (step_q == div_last(order_q)) begin
          step_d  = '0;
          state_d = (order_q == ORD_NANO) ? ST_OUT : ST_MAG;
        end
      end
      ST_MAG: begin
        acc_d  = u_y;
        step_d = step_q + 1'b1;
        if (step_q == mag_last(order_q)) begin
          step_d = '0;
          unique case (order_q) inside
            ORD_MEGA, ORD_KILO: state_d = ST_MUL;
            default:            state_d = ST_OUT;
          endcase
        end
      end
      ST_MUL: begin
        acc_d  = u_y;
        step_d = step_q + 1'b1;
        if (step_q == mul_last(order_q)) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          value_d     = {neg_q, acc_q};
          phase_d     = PH_START;
          neg_d       = 1'b0;
          int_d       = '0;
          frac_d      = '0;
          fcnt_d      = '0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_START;
      neg_q       <= 1'b0;
      int_q       <= '0;
      frac_q      <= '0;
      fcnt_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      order_q     <= ORD_ONE;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      int_q       <= int_d;
      frac_q      <= frac_d;
      fcnt_q      <= fcnt_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) order_q <= cfg_scale_order_i;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    value_q <= value_d;
  end

  a_pad_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV || state_q == ST_MAG) |-> (fcnt_q == PAD_DIGITS))
    else $error("fraction not padded before scaling");

  a_fcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= PAD_DIGITS)
    else $error("fraction digit count overflow");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frac_q < 30'd1000000000)
    else $error("fraction accumulator overflow");

  a_eot_starts_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && end_of_text_i) |=> (state_q == ST_PAD))
    else $error("end of text did not start finishing sequence");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_OUT))
    else $error("result beat without finishing sequence");

endmodule

### sv/dtnf_unit.sv
// Shared arithmetic unit: multiply-by-ten with addend, and divide-by-1000 of a
// fraction by reciprocal multiplication. Depends on dtnf_pkg.
module dtnf_unit (
  input  dtnf_pkg::unit_op_e           op_i,
  input  logic [dtnf_pkg::MAG_W-1:0]   a_i,
  input  logic [dtnf_pkg::MAG_W-1:0]   b_i,
  output logic [dtnf_pkg::MAG_W-1:0]   y_o
);
  import dtnf_pkg::*;

  logic [MAG_W-1:0]  mac;
  logic [PROD_W-1:0] prod;

  assign mac  = {a_i[MAG_W-4:0], 3'b000} + {a_i[MAG_W-2:0], 1'b0} + b_i;
  assign prod = PROD_W'(a_i[FRAC_W-1:0]) * PROD_W'(RECIP_1K);

  always_comb begin
    unique case (op_i)
      UOP_DIV: y_o = {{(MAG_W-QUOT_W){1'b0}}, prod[PROD_W-1:RECIP_SHIFT]};
      default: y_o = mac;
    endcase
  end

endmodule

### sv/dtnf_parse.sv
// Character classifier and parse phase update for one text beat.
// Depends on dtnf_pkg.
module dtnf_parse (
  input  dtnf_pkg::phase_e                phase_i,
  input  logic [7:0]                      char_i,
  input  logic [dtnf_pkg::CNT_W-1:0]      fcnt_i,
  output dtnf_pkg::parse_upd_t            upd_o
);
  import dtnf_pkg::*;

  logic is_digit;
  logic is_point;

  assign is_digit = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
  assign is_point = (char_i == CH_DOT) || (char_i == CH_COMMA);

  always_comb begin
    upd_o           = '0;
    upd_o.phase_nxt = phase_i;
    upd_o.digit     = char_i[3:0];
    unique case (phase_i)
      PH_START: begin
        if (char_i == CH_PLUS) begin
          upd_o.phase_nxt = PH_INT;
        end else if (char_i == CH_MINUS) begin
          upd_o.neg_set   = 1'b1;
          upd_o.phase_nxt = PH_INT;
        end else if (is_digit) begin
          upd_o.int_en    = 1'b1;
          upd_o.phase_nxt = PH_INT;
        end else if (is_point) begin
          upd_o.phase_nxt = PH_FRAC;
        end else begin
          upd_o.phase_nxt = PH_DONE;
        end
      end
      PH_INT: begin
        if (is_digit) begin
          upd_o.int_en = 1'b1;
        end else if (is_point) begin
          upd_o.phase_nxt = PH_FRAC;
        end else begin
          upd_o.phase_nxt = PH_DONE;
        end
      end
      PH_FRAC: begin
        if (is_digit && (fcnt_i < CNT_W'(FRACTION_DIGITS))) begin
          upd_o.frac_en = 1'b1;
        end else begin
          upd_o.phase_nxt = PH_DONE;
        end
      end
      default: upd_o.phase_nxt = PH_DONE;
    endcase
  end

endmodule
